// ----- hw/rtl/sidf_pkg.sv -----
// Shared constants, types and command/status bundles of the sorted intersect-difference filter.
`default_nettype none

package sidf_pkg;

    localparam int DEPTH  = 128;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    typedef logic [CNT_W-1:0]  count_t;
    typedef logic [ADDR_W-1:0] addr_t;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_LOAD_B = 2'd1,
        OP_LOAD_C = 2'd2,
        OP_FILTER = 2'd3
    } op_t;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } state_t;

    typedef struct packed {
        logic clear;
        logic load_b;
        logic load_c;
        logic start;
        logic step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic b_adv;
        logic c_adv;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/sidf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module sidf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                                       clk,
    input  wire logic                                       we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                           wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- hw/rtl/sidf_ctrl.sv -----
// Controller state machine: input handshake and sequencing of the pointer walk.
`default_nettype none

module sidf_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic [1:0]       operation,
    output logic                  in_ready,
    input  wire sidf_pkg::status_t status,
    output sidf_pkg::cmd_t        cmd
);

    sidf_pkg::state_t state_reg;
    sidf_pkg::state_t state_next;
    logic             accept;
    logic             walk_done;

    assign walk_done = !status.b_adv && !status.c_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sidf_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sidf_pkg::ST_IDLE:
            begin
                if (in_valid && operation == sidf_pkg::OP_FILTER)
                begin
                    state_next = sidf_pkg::ST_WALK;
                end
            end
            sidf_pkg::ST_WALK:
            begin
                if (walk_done && status.out_free)
                begin
                    state_next = sidf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sidf_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        cmd        = '0;
        accept     = 1'b0;
        case (state_reg)
            sidf_pkg::ST_IDLE:
            begin
                in_ready   = 1'b1;
                accept     = in_valid;
                cmd.clear  = accept && operation == sidf_pkg::OP_CLEAR;
                cmd.load_b = accept && operation == sidf_pkg::OP_LOAD_B;
                cmd.load_c = accept && operation == sidf_pkg::OP_LOAD_C;
                cmd.start  = accept && operation == sidf_pkg::OP_FILTER;
            end
            sidf_pkg::ST_WALK:
            begin
                cmd.step   = !walk_done;
                // hold the result until the output slot frees up
                cmd.finish = walk_done && status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hw/rtl/sidf_datapath.sv -----
// Datapath: B and C stores, counts, read pointers, compare logic and output register.
`default_nettype none

module sidf_datapath (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire sidf_pkg::cmd_t        cmd,
    output sidf_pkg::status_t          status,
    input  wire logic signed [31:0]    value,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic signed [31:0]         element,
    output logic                       keep
);

    sidf_pkg::count_t b_count_reg, b_count_next;
    sidf_pkg::count_t c_count_reg, c_count_next;
    sidf_pkg::count_t b_ptr_reg, b_ptr_next;
    sidf_pkg::count_t c_ptr_reg, c_ptr_next;

    logic signed [31:0] value_reg;
    logic signed [31:0] element_reg;
    logic               keep_reg;
    logic               out_valid_reg, out_valid_next;

    logic [sidf_pkg::DATA_W-1:0] b_rdata;
    logic [sidf_pkg::DATA_W-1:0] c_rdata;
    logic                        b_we;
    logic                        c_we;
    logic                        b_live;
    logic                        c_live;
    logic                        b_eq;
    logic                        c_eq;

    assign b_we = cmd.load_b && (b_count_reg < sidf_pkg::CNT_W'(sidf_pkg::DEPTH));
    assign c_we = cmd.load_c && (c_count_reg < sidf_pkg::CNT_W'(sidf_pkg::DEPTH));

    // read address follows the next pointer, so read data matches it during a walk
    sidf_ram #(
        .WIDTH (sidf_pkg::DATA_W),
        .DEPTH (sidf_pkg::DEPTH)
    ) u_b_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_count_reg[sidf_pkg::ADDR_W-1:0]),
        .wdata (value),
        .raddr (b_ptr_next[sidf_pkg::ADDR_W-1:0]),
        .rdata (b_rdata)
    );

    sidf_ram #(
        .WIDTH (sidf_pkg::DATA_W),
        .DEPTH (sidf_pkg::DEPTH)
    ) u_c_ram (
        .clk   (clk),
        .we    (c_we),
        .waddr (c_count_reg[sidf_pkg::ADDR_W-1:0]),
        .wdata (value),
        .raddr (c_ptr_next[sidf_pkg::ADDR_W-1:0]),
        .rdata (c_rdata)
    );

    assign b_live = b_ptr_reg < b_count_reg;
    assign c_live = c_ptr_reg < c_count_reg;
    assign b_eq   = b_live && ($signed(b_rdata) == value_reg);
    assign c_eq   = c_live && ($signed(c_rdata) == value_reg);

    assign status.b_adv    = b_live && ($signed(b_rdata) < value_reg);
    assign status.c_adv    = c_live && ($signed(c_rdata) < value_reg);
    assign status.out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        b_count_next = b_count_reg;
        c_count_next = c_count_reg;
        b_ptr_next   = b_ptr_reg;
        c_ptr_next   = c_ptr_reg;
        if (cmd.clear)
        begin
            b_count_next = '0;
            c_count_next = '0;
            b_ptr_next   = '0;
            c_ptr_next   = '0;
        end
        if (b_we)
        begin
            b_count_next = b_count_reg + 1'b1;
        end
        if (c_we)
        begin
            c_count_next = c_count_reg + 1'b1;
        end
        if (cmd.step && status.b_adv)
        begin
            b_ptr_next = b_ptr_reg + 1'b1;
        end
        if (cmd.step && status.c_adv)
        begin
            c_ptr_next = c_ptr_reg + 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_count_reg   <= '0;
            c_count_reg   <= '0;
            b_ptr_reg     <= '0;
            c_ptr_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            b_count_reg   <= b_count_next;
            c_count_reg   <= c_count_next;
            b_ptr_reg     <= b_ptr_next;
            c_ptr_reg     <= c_ptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            value_reg <= value;
        end
        if (cmd.finish)
        begin
            element_reg <= value_reg;
            keep_reg    <= !(b_eq && c_eq);
        end
    end

    assign out_valid = out_valid_reg;
    assign element   = element_reg;
    assign keep      = keep_reg;

`ifndef NO_ASSERTIONS
    a_b_ptr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        b_ptr_reg <= b_count_reg)
        else $error("B pointer ran past B count");

    a_c_ptr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        c_ptr_reg <= c_count_reg)
        else $error("C pointer ran past C count");

    a_finish_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid_reg)
        else $error("finished walk did not present a result");

    a_no_step_on_finish: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.step && cmd.finish))
        else $error("pointer step and finish in the same cycle");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/sorted_intersect_difference_filter_unit.sv -----
// Top level of the sorted intersect-difference filter: A minus (B intersect C).
//
//  channel | signals                           | direction
//  --------+-----------------------------------+----------
//  input   | in_valid, in_ready, operation,    | in
//          | value                             |
//  output  | out_valid, out_ready, element,    | out
//          | keep                              |
//
// Clear and load transactions are accepted while the unit is idle. A filter
// transaction advances the B and C pointers past stored elements below its
// value, each on its own, one stored element per cycle through the registered
// read port of each store. Reset clears counts, pointers and output valid;
// store contents are not cleared. A result not yet taken holds the walk in its
// final cycle until the output slot frees, while the next transaction is held.
`default_nettype none

module sorted_intersect_difference_filter_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         operation,
    input  wire logic signed [31:0] value,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [31:0]      element,
    output logic                    keep
);

    sidf_pkg::cmd_t    cmd;
    sidf_pkg::status_t status;

    sidf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .operation (operation),
        .in_ready  (in_ready),
        .status    (status),
        .cmd       (cmd)
    );

    sidf_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .element   (element),
        .keep      (keep)
    );

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
// Self-checking testbench for the sorted intersect-difference filter unit.
module tb;

    localparam int RUN_ITEMS    = 1800;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int IDLE_PCT     = 36;
    localparam int STALL_CYCLES = 400;
    localparam int DRAIN_CYCLES = sidf_pkg::DEPTH + 40;

    localparam logic signed [sidf_pkg::DATA_W-1:0] VMIN = 32'sh8000_0000;
    localparam logic signed [sidf_pkg::DATA_W-1:0] VMAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic signed [sidf_pkg::DATA_W-1:0] element;
        logic                               keep;
    } verdict_t;

    class filter_verdict_board;
        // index 0 holds list B, index 1 holds list C
        logic signed [sidf_pkg::DATA_W-1:0] list_data [2][sidf_pkg::DEPTH];
        int unsigned list_len [2];
        int unsigned list_pos [2];
        verdict_t verdicts_due [$];
        int errors;
        int results;
        int drops;
        int full_loads;

        function void note_transaction(sidf_pkg::op_t op,
                                       logic signed [sidf_pkg::DATA_W-1:0] v);
            int k;
            logic in_both;
            verdict_t due;
            case (op)
                sidf_pkg::OP_CLEAR:
                begin
                    for (k = 0; k < 2; k++)
                    begin
                        list_len[k] = 0;
                        list_pos[k] = 0;
                    end
                end
                sidf_pkg::OP_LOAD_B, sidf_pkg::OP_LOAD_C:
                begin
                    k = (op == sidf_pkg::OP_LOAD_B) ? 0 : 1;
                    if (list_len[k] < sidf_pkg::DEPTH)
                    begin
                        list_data[k][list_len[k]] = v;
                        list_len[k]++;
                    end
                    else
                        full_loads++;
                end
                default:
                begin
                    in_both = 1'b1;
                    for (k = 0; k < 2; k++)
                    begin
                        // advance past smaller entries; pointers move back only on a clear
                        while (list_pos[k] < list_len[k] && list_data[k][list_pos[k]] < v)
                            list_pos[k]++;
                        if (!(list_pos[k] < list_len[k] && list_data[k][list_pos[k]] == v))
                            in_both = 1'b0;
                    end
                    due.element = v;
                    due.keep    = !in_both;
                    verdicts_due.push_back(due);
                end
            endcase
        endfunction

        function void check_result(logic signed [sidf_pkg::DATA_W-1:0] element, logic keep);
            verdict_t due;
            results++;
            if (verdicts_due.size() == 0)
            begin
                errors++;
                $error("unexpected result: element %0d keep %0b", element, keep);
                return;
            end
            due = verdicts_due.pop_front();
            if (!due.keep)
                drops++;
            if (element !== due.element)
            begin
                errors++;
                $error("element: expected %0d, actual %0d", due.element, element);
            end
            if (keep !== due.keep)
            begin
                errors++;
                $error("keep: expected %0b, actual %0b", due.keep, keep);
            end
        endfunction

        function int pending();
            return verdicts_due.size();
        endfunction
    endclass

    logic                               clk       = 1'b0;
    logic                               rst_n     = 1'b0;
    logic                               in_valid  = 1'b0;
    logic                               out_ready = 1'b0;
    logic [1:0]                         operation = sidf_pkg::OP_CLEAR;
    logic signed [sidf_pkg::DATA_W-1:0] value     = '0;
    logic                               in_ready;
    logic                               out_valid;
    logic signed [sidf_pkg::DATA_W-1:0] element;
    logic                               keep;

    filter_verdict_board board;
    int unsigned sent      = 0;
    int unsigned cycles    = 0;
    int          hold_left = 0;
    bit          calm      = 1'b0;
    bit          held      = 1'b0;

    sorted_intersect_difference_filter_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .element   (element),
        .keep      (keep)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                board.note_transaction(sidf_pkg::op_t'(operation), value);
            if (out_valid && out_ready)
                board.check_result(element, keep);
        end
    end

    // receiver: random back-pressure plus one long hold-off to fill the block
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (!held && board.results >= 150)
            begin
                held      = 1'b1;
                hold_left = STALL_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
                out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("CHECK FAILED");
        $finish;
    end

    task automatic send(sidf_pkg::op_t op, logic signed [sidf_pkg::DATA_W-1:0] v);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        value     <= v;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        sent++;
        calm = (sent >= 700 && sent < 1000);
    endtask

    // non-decreasing run unless it wraps past VMAX; scramble drops random values in to break the order
    task automatic send_run(sidf_pkg::op_t op, logic signed [sidf_pkg::DATA_W-1:0] start,
                            int len, int stride, bit scramble);
        logic signed [sidf_pkg::DATA_W-1:0] v;
        v = start;
        for (int i = 0; i < len; i++)
        begin
            v += $urandom_range(0, stride);
            if (scramble && $urandom_range(0, 5) == 0)
                send(op, $urandom);
            else
                send(op, v);
        end
    endtask

    function automatic int list_size();
        int pick;
        pick = $urandom_range(0, 11);
        if (pick == 0)
            return $urandom_range(110, 140);
        if (pick == 1)
            return 0;
        return $urandom_range(1, 16);
    endfunction

    task automatic run_sequence();
        logic signed [sidf_pkg::DATA_W-1:0] base;
        int b_len;
        int c_len;
        int a_len;
        int stride;
        int a_stride;
        bit mess;
        case ($urandom_range(0, 5))
            0:       base = VMIN + $urandom_range(0, 20);
            1:       base = VMAX - $urandom_range(0, 300);
            default: base = $urandom;
        endcase
        stride   = $urandom_range(1, 4);
        b_len    = list_size();
        c_len    = list_size();
        a_len    = $urandom_range(1, 24);
        a_stride = stride * ((b_len > c_len) ? b_len : c_len) / a_len + 1;
        mess     = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 7) != 0)
            send(sidf_pkg::OP_CLEAR, $urandom);
        send_run(sidf_pkg::OP_LOAD_B, base, b_len, stride, mess);
        send_run(sidf_pkg::OP_LOAD_C, base + $urandom_range(0, 2), c_len, stride, mess);
        send_run(sidf_pkg::OP_FILTER, base - $urandom_range(0, 3), a_len, a_stride, mess);
        if ($urandom_range(0, 3) == 0)
        begin
            // append after filtering, then filter again starting at the appended base
            base = base + stride * c_len;
            send_run(sidf_pkg::OP_LOAD_B, base, $urandom_range(1, 4), stride, 1'b0);
            send_run(sidf_pkg::OP_LOAD_C, base, $urandom_range(1, 4), stride, 1'b0);
            send_run(sidf_pkg::OP_FILTER, base, $urandom_range(1, 6), stride, 1'b0);
        end
        if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 6))
                send(sidf_pkg::op_t'($urandom_range(0, 3)), $urandom);
    endtask

    initial
    begin
        logic signed [sidf_pkg::DATA_W-1:0] dir_b [5];
        logic signed [sidf_pkg::DATA_W-1:0] dir_c [5];
        logic signed [sidf_pkg::DATA_W-1:0] dir_a [8];
        dir_b = '{VMIN, -32'sd1, 32'sd0, 32'sd7, VMAX};
        dir_c = '{VMIN, 32'sd0, 32'sd0, 32'sd9, VMAX};
        // duplicates, a value only in B, and an out-of-order value in A
        dir_a = '{VMIN, VMIN, -32'sd5, 32'sd0, 32'sd7, 32'sd9, 32'sd3, VMAX};
        board = new();
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        send(sidf_pkg::OP_CLEAR, 32'h5A5A_A5A5);
        send(sidf_pkg::OP_FILTER, 32'sd5);
        foreach (dir_b[i]) send(sidf_pkg::OP_LOAD_B, dir_b[i]);
        foreach (dir_c[i]) send(sidf_pkg::OP_LOAD_C, dir_c[i]);
        foreach (dir_a[i]) send(sidf_pkg::OP_FILTER, dir_a[i]);
        send(sidf_pkg::OP_LOAD_B, VMAX);
        send(sidf_pkg::OP_FILTER, VMAX);

        while (sent - board.full_loads < RUN_ITEMS) run_sequence();
        in_valid <= 1'b0;

        while (board.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.pending() != 0)
        begin
            board.errors++;
            $error("%0d filter results never arrived", board.pending());
        end

        $display("Sent %0d transactions, %0d of them loads into a full store, in %0d cycles.",
                 sent, board.full_loads, cycles);
        $display("Checked %0d filter results, %0d dropped as common to B and C.",
                 board.results, board.drops);
        if (board.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
